FILE: rtl/core/b64e_pkg.sv
// Shared types, constants and the character map of the Base64 encoder.
package b64e_pkg;

    // Queue depth between front and back (groups)
    localparam int unsigned QUEUE_DEPTH = 2;

    // Phase codes: bytes held in the current group
    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    // Padding character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Position of the last character within a group
    localparam logic [1:0] LAST_SLOT = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } t_out_item;

    // One encoded group of four characters; chars[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            fin;
    } t_group;

    // 6-bit value to alphabet character (A-Z a-z 0-9 + /)
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        case (v) inside
            [6'd0:6'd25]:  c = w + 8'd65;
            [6'd26:6'd51]: c = w + 8'd71;
            [6'd52:6'd61]: c = w - 8'd4;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/base64_encoder_unit.sv
// Top level of the Base64 encoder: front end, group queue and back end.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (byte, last flag)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (char, last flag)
//
// A byte request is taken every cycle while the queue has room for the group it closes.
// Output runs at one character per cycle unless stalled, four per group; the rate is set
// by the single back-end output register.
// A closed group moves via the queue and the group register to the output register.
// Reset (synchronous, active low) empties the queue and clears the group phase.
// Output stall holds the character; a full queue stalls only closing bytes.
module base64_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  b64e_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output b64e_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    b64e_pkg::t_group push_group;
    b64e_pkg::t_group head_group;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in_data),
        .o_stall  (o_in_stall),
        .i_q_full (q_full),
        .o_push   (push),
        .o_group  (push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_group (head_group)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_group   (head_group),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .o_item    (o_out_data),
        .i_stall   (i_out_stall)
    );

endmodule

FILE: rtl/core/b64e_front.sv
// Front end: gathers bytes into groups and encodes each finished group.
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  b64e_pkg::t_in_item  i_item,
    output logic                o_stall,
    input  logic                i_q_full,
    output logic                o_push,
    output b64e_pkg::t_group    o_group
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic       need_push;
    logic       accept;
    logic [7:0] b;
    logic       fin;

    assign b   = i_item.data_byte;
    assign fin = i_item.final_byte;

    // A request that closes a group needs a free queue slot
    assign need_push = fin || (r_phase == b64e_pkg::PHASE_TWO);
    assign o_stall   = need_push && i_q_full;
    assign accept    = i_valid && !o_stall;
    assign o_push    = accept && need_push;

    // Encode the group this request would close
    always_comb begin
        o_group.fin = fin;
        case (r_phase)
            b64e_pkg::PHASE_ONE: begin
                o_group.chars[0] = b64e_pkg::b64_char(r_first[7:2]);
                o_group.chars[1] = b64e_pkg::b64_char({r_first[1:0], b[7:4]});
                o_group.chars[2] = b64e_pkg::b64_char({b[3:0], 2'b00});
                o_group.chars[3] = b64e_pkg::PAD_CHAR;
            end
            b64e_pkg::PHASE_TWO: begin
                o_group.chars[0] = b64e_pkg::b64_char(r_first[7:2]);
                o_group.chars[1] = b64e_pkg::b64_char({r_first[1:0], r_second[7:4]});
                o_group.chars[2] = b64e_pkg::b64_char({r_second[3:0], b[7:6]});
                o_group.chars[3] = b64e_pkg::b64_char(b[5:0]);
            end
            default: begin
                o_group.chars[0] = b64e_pkg::b64_char(b[7:2]);
                o_group.chars[1] = b64e_pkg::b64_char({b[1:0], 4'b0000});
                o_group.chars[2] = b64e_pkg::PAD_CHAR;
                o_group.chars[3] = b64e_pkg::PAD_CHAR;
            end
        endcase
    end

    // Phase and pending bytes
    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        if (accept) begin
            if (need_push) begin
                n_phase = b64e_pkg::PHASE_EMPTY;
            end else if (r_phase == b64e_pkg::PHASE_ONE) begin
                n_second = b;
                n_phase  = b64e_pkg::PHASE_TWO;
            end else begin
                n_first = b;
                n_phase = b64e_pkg::PHASE_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= b64e_pkg::PHASE_EMPTY;
            r_first  <= 8'd0;
            r_second <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

FILE: rtl/core/b64e_queue.sv
// Short queue of encoded groups between front and back.
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64e_pkg::t_group  i_group,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output b64e_pkg::t_group  o_group
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_group = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_group;
        end
    end

endmodule

FILE: rtl/core/b64e_back.sv
// Back end: sends a group's four characters, one per cycle unless stalled.
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  b64e_pkg::t_group    i_group,
    output logic                o_pop,
    output logic                o_valid,
    output b64e_pkg::t_out_item o_item,
    input  logic                i_stall
);

    b64e_pkg::t_group    r_group, n_group;
    logic [1:0]          r_idx, n_idx;
    logic                r_busy, n_busy;
    logic                r_out_valid, n_out_valid;
    b64e_pkg::t_out_item r_out, n_out;
    logic                slot_free;
    logic                emit;
    logic                last;

    assign slot_free = !r_out_valid || !i_stall;
    assign emit      = r_busy && slot_free;
    assign last      = emit && (r_idx == b64e_pkg::LAST_SLOT);
    assign o_pop     = i_q_valid && (!r_busy || last);
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    // Group holding and output register
    always_comb begin
        n_group     = r_group;
        n_idx       = r_idx;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.char_code  = r_group.chars[r_idx];
            n_out.final_char = r_group.fin && (r_idx == b64e_pkg::LAST_SLOT);
            n_idx            = r_idx + 1'b1;
            if (last) begin
                n_busy = 1'b0;
            end
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_pop) begin
            n_group = i_group;
            n_idx   = 2'd0;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_group <= n_group;
        r_out   <= n_out;
    end

endmodule

FILE: rtl/core/b64e_checker.sv
// Port-level checks for the Base64 encoder and their binding to the top level.
module b64e_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input b64e_pkg::t_in_item  i_in_data,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input b64e_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);

    // Reset leaves no character on the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled character changed");

    // Padding that is not last is followed at once by more padding
    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.final_char
            && (o_out_data.char_code == b64e_pkg::PAD_CHAR)
        |=> o_out_valid && (o_out_data.char_code == b64e_pkg::PAD_CHAR))
        else $error("padding sequence broken");

    // Input stalls only while a character is pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with idle output");

endmodule

bind base64_encoder_unit b64e_checker u_b64e_checker (.*);
